// ===== sv/tcq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcq_pkg: shared types and constants for the two class queue.
// Holds the operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package tcq_pkg;
	localparam int DEPTH_DEF     = 256;
	localparam int SIZE_BITS_DEF = 48;
	localparam int TAG_BITS_DEF  = 16;
	localparam int COUNT_BITS    = 9;

	localparam logic [1:0] OP_INS_FILE = 2'd0;
	localparam logic [1:0] OP_INS_DIR  = 2'd1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_RETURNED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_LAST, S_READ, S_MOVE, S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== sv/tcq_store.sv =====
// ----------------------------------------------------------------------------
// tcq_store: entry memory for both classes.
// One write port and one registered read port; the class bit selects the half.
// ----------------------------------------------------------------------------
`default_nettype none
module tcq_store import tcq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int W = 64
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(DEPTH):0] waddr,
	input  wire logic [W-1:0] wdata,
	input  wire logic [$clog2(DEPTH):0] raddr,
	output logic [W-1:0] rdata
);
	// Each half spans the full power-of-two index range of one class.
	logic [W-1:0] mem [2**($clog2(DEPTH)+1)];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/two_class_smallest_first_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_class_smallest_first_queue_unit: file and directory min queues.
// An insert goes from idle straight to done, which gives the strobe. A take
// scans every entry of the chosen class through one shared compare, one entry
// read per cycle, then runs the last, read and move states; a take on empty
// queues goes to done. The next start is accepted the cycle after the strobe.
// The receiver cannot stall. Reset clears counts and the sequencer, not memory.
// ----------------------------------------------------------------------------
`default_nettype none
module two_class_smallest_first_queue_unit import tcq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF,
	parameter int TAG_BITS  = TAG_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [1:0] operation,
	input  wire logic [SIZE_BITS-1:0] size_key,
	input  wire logic [TAG_BITS-1:0] tag,
	output logic done,
	output logic [1:0] status,
	output logic [SIZE_BITS-1:0] out_size,
	output logic [TAG_BITS-1:0] out_tag,
	output logic out_is_dir,
	output logic [COUNT_BITS-1:0] file_count,
	output logic [COUNT_BITS-1:0] dir_count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int W  = SIZE_BITS + TAG_BITS;

	state_t state_q, state_d;
	logic [CW-1:0] fcnt_q, dcnt_q, cnt_sel;
	logic [CW-1:0] idx_q;        // next address to read
	logic [AW-1:0] best_idx_q, cmp_idx_q;
	logic [W-1:0]  best_q;
	logic          first_q, cls_q, cmp_vld_q;
	logic [1:0]    status_q;
	logic [W-1:0]  rdata, wdata;
	logic          we;
	logic [CW-1:0] waddr, raddr;

	// The class selects the half of the store; the count of that class is
	// the number of live entries.
	assign cnt_sel = cls_q ? dcnt_q : fcnt_q;

	tcq_store #(.DEPTH(DEPTH), .W(W)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = '0;
		wdata = best_q;
		raddr = {cls_q, idx_q[AW-1:0]};
		case (state_q)
			S_IDLE: begin
				raddr = '0;
				if (start) state_d = S_DONE;
				if (start && operation != OP_INS_FILE && operation != OP_INS_DIR
						&& (fcnt_q != '0 || dcnt_q != '0))
					state_d = S_SCAN;
				// Inserts write straight into the slot after the last entry.
				if (start && (operation == OP_INS_FILE || operation == OP_INS_DIR)) begin
					we = (operation == OP_INS_FILE) ? (fcnt_q != CW'(DEPTH))
						: (dcnt_q != CW'(DEPTH));
					waddr = {operation[0],
						(operation[0] ? dcnt_q[AW-1:0] : fcnt_q[AW-1:0])};
					wdata = {size_key, tag};
				end
			end
			S_SCAN: if (idx_q == cnt_sel) state_d = S_LAST;
			S_LAST: state_d = S_READ;
			S_READ: begin
				raddr = {cls_q, AW'(cnt_sel - CW'(1))};
				state_d = S_MOVE;
			end
			S_MOVE: begin
				// The last entry fills the hole left by the minimum.
				we = 1'b1;
				waddr = {cls_q, best_idx_q};
				wdata = rdata;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fcnt_q <= '0;
			dcnt_q <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_vld_q <= (state_q == S_SCAN && idx_q != cnt_sel);
			if (state_q == S_IDLE && start) begin
				if (operation == OP_INS_FILE && fcnt_q != CW'(DEPTH))
					fcnt_q <= fcnt_q + CW'(1);
				if (operation == OP_INS_DIR && dcnt_q != CW'(DEPTH))
					dcnt_q <= dcnt_q + CW'(1);
			end
			if (state_q == S_MOVE) begin
				if (cls_q) dcnt_q <= dcnt_q - CW'(1);
				else fcnt_q <= fcnt_q - CW'(1);
			end
		end
	end

	// Datapath: one compare per cycle against the running minimum.
	always_ff @(posedge clk) begin
		cmp_idx_q <= idx_q[AW-1:0];
		if (state_q == S_IDLE && start) begin
			idx_q <= '0;
			first_q <= 1'b1;
			cls_q <= (fcnt_q == '0);
			best_q <= '0;
			if (operation == OP_INS_FILE)
				status_q <= (fcnt_q == CW'(DEPTH)) ? ST_FULL : ST_INSERTED;
			else if (operation == OP_INS_DIR)
				status_q <= (dcnt_q == CW'(DEPTH)) ? ST_FULL : ST_INSERTED;
			else
				status_q <= (fcnt_q == '0 && dcnt_q == '0) ? ST_EMPTY : ST_RETURNED;
		end
		if (state_q == S_SCAN && idx_q != cnt_sel) idx_q <= idx_q + CW'(1);
		if (cmp_vld_q && (first_q || rdata < best_q)) begin
			best_q <= rdata;
			best_idx_q <= cmp_idx_q;
			first_q <= 1'b0;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = status_q;
	assign out_size = (status_q == ST_RETURNED) ? best_q[W-1:TAG_BITS] : '0;
	assign out_tag = (status_q == ST_RETURNED) ? best_q[TAG_BITS-1:0] : '0;
	assign out_is_dir = (status_q == ST_RETURNED) & cls_q;
	assign file_count = COUNT_BITS'(fcnt_q);
	assign dir_count = COUNT_BITS'(dcnt_q);

	a_cnt_f: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CW'(DEPTH)) else $error("file count over depth");
	a_cnt_d: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CW'(DEPTH)) else $error("dir count over depth");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after strobe");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |-> cnt_sel != '0) else $error("take from empty class");
endmodule
`default_nettype wire
